// ----- hw/rtl/spi_pkg.sv -----
package spi_pkg;

  // unit vector components: signed Q2.30
  localparam int UNIT_W    = 32;
  localparam int UNIT_FRAC = 30;

  // result status codes
  localparam logic [1:0] ST_HIT      = 2'd0;
  localparam logic [1:0] ST_ON_PLANE = 2'd1;
  localparam logic [1:0] ST_ONE_SIDE = 2'd2;
  localparam logic [1:0] ST_OUT_SPAN = 2'd3;

  // configuration register indexes
  localparam int          REG_IDX_W        = 3;
  localparam logic [2:0]  REG_NORMAL_X     = 3'd0;
  localparam logic [2:0]  REG_NORMAL_Y     = 3'd1;
  localparam logic [2:0]  REG_NORMAL_Z     = 3'd2;
  localparam logic [2:0]  REG_PLANE_OFFSET = 3'd3;
  localparam logic [2:0]  REG_TOL_LINE     = 3'd4;
  localparam logic [2:0]  REG_TOL_PLANE    = 3'd5;

  // reset value of the normal z component: 1.0 in Q2.30
  localparam logic signed [UNIT_W-1:0] NORMAL_Z_RESET = 32'sh4000_0000;

endpackage

// ----- hw/rtl/segment_plane_intersect.sv -----
// Pipeline from the start transfer to the done strobe: 7 geometry stages, one
// restoring-division stage per quotient bit (COORD_WIDTH+1 of them) and 4 stages
// for rounding, window and hit point.
// Throughput: one segment per clock, every clock; busy is high only during reset.
// Reset (rst, synchronous) empties the pipeline and loads the plane registers with
// normal (0,0,1), offset 0 and zero tolerances. Results are never held back.
module segment_plane_intersect
  import spi_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                            clk,
  input  logic                                            rst,
  // configuration write port
  input  logic                                            wr_en,
  input  logic [REG_IDX_W-1:0]                            wr_index,
  input  logic [((COORD_WIDTH > UNIT_W) ? COORD_WIDTH : UNIT_W)-1:0] wr_data,
  // command side
  input  logic                                            start,
  output logic                                            busy,
  input  logic signed [COORD_WIDTH-1:0]                   origin_x,
  input  logic signed [COORD_WIDTH-1:0]                   origin_y,
  input  logic signed [COORD_WIDTH-1:0]                   origin_z,
  input  logic signed [UNIT_W-1:0]                        dir_x,
  input  logic signed [UNIT_W-1:0]                        dir_y,
  input  logic signed [UNIT_W-1:0]                        dir_z,
  input  logic signed [COORD_WIDTH-1:0]                   t_start,
  input  logic signed [COORD_WIDTH-1:0]                   t_end,
  // result side, one-cycle strobe
  output logic                                            done,
  output logic [1:0]                                      status,
  output logic signed [COORD_WIDTH-1:0]                   t_hit,
  output logic signed [COORD_WIDTH-1:0]                   hit_x,
  output logic signed [COORD_WIDTH-1:0]                   hit_y,
  output logic signed [COORD_WIDTH-1:0]                   hit_z,
  output logic [COORD_WIDTH-2:0]                          tol_sum,
  output logic signed [COORD_WIDTH-1:0]                   t_low,
  output logic signed [COORD_WIDTH-1:0]                   t_high
);

  localparam int CW = COORD_WIDTH;
  localparam int BW = (CW > UNIT_W) ? CW : UNIT_W;
  // widest exact product, and its width after the Q2.30 rescale
  localparam int MW = BW + 35;
  localparam int RW = MW - UNIT_FRAC;
  // quotient bits: any |t| at or above 2^(CW+1) is outside every span
  localparam int NQ = CW + 1;
  localparam int TW = CW + 3;

  localparam logic [MW-1:0]        HALF = MW'(1) << (UNIT_FRAC - 1);
  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    logic [2:0][CW-1:0]     o;
    logic [2:0][UNIT_W-1:0] u;
    logic [CW-1:0]          ts;
    logic [CW-1:0]          te;
  } pass_t;

  typedef struct packed {
    logic          valid;
    pass_t         ps;
    logic          early;   // status already settled before the division
    logic [1:0]    est;
    logic          neg;     // quotient sign
    logic [RW-1:0] uh;      // divisor magnitude
    logic [RW-1:0] r;       // partial remainder
    logic [NQ-1:0] q;
    logic [NQ-1:0] dlo;     // dividend bits still to shift in
  } div_t;

  // product >> 30, rounded half away from zero
  function automatic logic signed [RW-1:0] rnd(input logic signed [MW-1:0] x);
    logic [MW-1:0] m;
    logic [MW-1:0] s;
    logic [RW-1:0] v;
    m = x[MW-1] ? $unsigned(-x) : $unsigned(x);
    s = m + HALF;
    v = s[MW-1:UNIT_FRAC];
    rnd = x[MW-1] ? -$signed(v) : $signed(v);
  endfunction

  function automatic logic signed [CW-1:0] sat_c(input logic signed [RW-1:0] x);
    if (x > RW'(CMAX)) begin
      sat_c = CMAX;
    end else if (x < RW'(CMIN)) begin
      sat_c = CMIN;
    end else begin
      sat_c = x[CW-1:0];
    end
  endfunction

  // ---------------------------------------------------------------- plane registers
  logic signed [UNIT_W-1:0] nrm [3];
  logic signed [CW-1:0]     offs;
  logic [CW-3:0]            tl;
  logic [CW-3:0]            tp;
  logic [CW-2:0]            tol;

  always_ff @(posedge clk) begin
    if (rst) begin
      nrm[0] <= '0;
      nrm[1] <= '0;
      nrm[2] <= NORMAL_Z_RESET;
      offs   <= '0;
      tl     <= '0;
      tp     <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_NORMAL_X:     nrm[0] <= wr_data[UNIT_W-1:0];
        REG_NORMAL_Y:     nrm[1] <= wr_data[UNIT_W-1:0];
        REG_NORMAL_Z:     nrm[2] <= wr_data[UNIT_W-1:0];
        REG_PLANE_OFFSET: offs   <= wr_data[CW-1:0];
        REG_TOL_LINE:     tl     <= wr_data[CW-3:0];
        REG_TOL_PLANE:    tp     <= wr_data[CW-3:0];
        default: ;
      endcase
    end
  end

  // tolerance sum is taken live: the user must change the registers only while the pipe is empty (not enforced here)
  assign tol = {1'b0, tl} + {1'b0, tp};

  // ---------------------------------------------------------------- input
  logic                     in_take;
  logic signed [CW-1:0]     in_o [3];
  logic signed [UNIT_W-1:0] in_u [3];

  assign busy    = rst;
  assign in_take = start & ~busy;
  assign in_o[0] = origin_x;
  assign in_o[1] = origin_y;
  assign in_o[2] = origin_z;
  assign in_u[0] = dir_x;
  assign in_u[1] = dir_y;
  assign in_u[2] = dir_z;

  // ---------------------------------------------------------------- S1: products
  logic                          v1;
  pass_t                         ps1;
  logic signed [CW+UNIT_W-1:0]   m_tsu [3];
  logic signed [CW+UNIT_W-1:0]   m_teu [3];
  logic signed [CW+UNIT_W-1:0]   m_no  [3];
  logic signed [2*UNIT_W-1:0]    m_nu  [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_take;
    end
    ps1.ts <= t_start;
    ps1.te <= t_end;
    for (int i = 0; i < 3; i++) begin
      ps1.o[i] <= in_o[i];
      ps1.u[i] <= in_u[i];
      m_tsu[i] <= t_start * in_u[i];
      m_teu[i] <= t_end * in_u[i];
      m_no[i]  <= nrm[i] * in_o[i];
      m_nu[i]  <= nrm[i] * in_u[i];
    end
  end

  // ---------------------------------------------------------------- S2: rescale
  logic                 v2;
  pass_t                ps2;
  logic signed [RW-1:0] r_tsu [3];
  logic signed [RW-1:0] r_teu [3];
  logic signed [RW-1:0] r_no  [3];
  logic signed [RW-1:0] r_nu  [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    ps2 <= ps1;
    for (int i = 0; i < 3; i++) begin
      r_tsu[i] <= rnd(MW'(m_tsu[i]));
      r_teu[i] <= rnd(MW'(m_teu[i]));
      r_no[i]  <= rnd(MW'(m_no[i]));
      r_nu[i]  <= rnd(MW'(m_nu[i]));
    end
  end

  // ---------------------------------------------------------------- S3: endpoints, n.o+d, n.u
  logic                 v3;
  pass_t                ps3;
  logic signed [CW+1:0] p_s [3];
  logic signed [CW+1:0] p_e [3];
  logic signed [RW-1:0] e3;
  logic signed [RW-1:0] h3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    ps3 <= ps2;
    for (int i = 0; i < 3; i++) begin
      p_s[i] <= (CW+2)'(RW'($signed(ps2.o[i])) + r_tsu[i]);
      p_e[i] <= (CW+2)'(RW'($signed(ps2.o[i])) + r_teu[i]);
    end
    e3 <= r_no[0] + r_no[1] + r_no[2] + RW'(offs);
    h3 <= r_nu[0] + r_nu[1] + r_nu[2];
  end

  // ---------------------------------------------------------------- S4: n.p products
  logic                          v4;
  pass_t                         ps4;
  logic signed [RW-1:0]          e4;
  logic signed [RW-1:0]          h4;
  logic signed [CW+UNIT_W+1:0]   m_ns [3];
  logic signed [CW+UNIT_W+1:0]   m_ne [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    ps4 <= ps3;
    e4  <= e3;
    h4  <= h3;
    for (int i = 0; i < 3; i++) begin
      m_ns[i] <= nrm[i] * p_s[i];
      m_ne[i] <= nrm[i] * p_e[i];
    end
  end

  // ---------------------------------------------------------------- S5: rescale
  logic                 v5;
  pass_t                ps5;
  logic signed [RW-1:0] e5;
  logic signed [RW-1:0] h5;
  logic signed [RW-1:0] r_ns [3];
  logic signed [RW-1:0] r_ne [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    ps5 <= ps4;
    e5  <= e4;
    h5  <= h4;
    for (int i = 0; i < 3; i++) begin
      r_ns[i] <= rnd(MW'(m_ns[i]));
      r_ne[i] <= rnd(MW'(m_ne[i]));
    end
  end

  // ---------------------------------------------------------------- S6: distances, magnitudes
  logic                 v6;
  pass_t                ps6;
  logic signed [RW-1:0] d1;
  logic signed [RW-1:0] d2;
  logic [RW-1:0]        ue;
  logic [RW-1:0]        uh;
  logic                 neg6;
  logic                 hz6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
    ps6  <= ps5;
    d1   <= r_ns[0] + r_ns[1] + r_ns[2] + RW'(offs);
    d2   <= r_ne[0] + r_ne[1] + r_ne[2] + RW'(offs);
    ue   <= e5[RW-1] ? $unsigned(-e5) : $unsigned(e5);
    uh   <= h5[RW-1] ? $unsigned(-h5) : $unsigned(h5);
    neg6 <= (e5[RW-1] == h5[RW-1]);
    hz6  <= (h5 == '0);
  end

  // ---------------------------------------------------------------- S7: classify, set up divide
  logic [RW-1:0]    ad1;
  logic [RW-1:0]    ad2;
  logic [RW+29:0]   dd;
  logic [RW+29:0]   dd_hi;
  logic             on_pl;
  logic             one_sd;
  logic             ovf;
  div_t             dv [NQ+1];

  always_comb begin
    ad1    = d1[RW-1] ? $unsigned(-d1) : $unsigned(d1);
    ad2    = d2[RW-1] ? $unsigned(-d2) : $unsigned(d2);
    on_pl  = (ad1 < RW'(tol)) && (ad2 < RW'(tol));
    one_sd = ((d1 > 0) && (d2 > 0)) || ((d1 < 0) && (d2 < 0));
    dd     = {ue, {UNIT_FRAC{1'b0}}};
    dd_hi  = dd >> NQ;
    // quotient would need more than NQ bits: far outside any span
    ovf    = dd_hi >= (RW+30)'(uh);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0].valid <= 1'b0;
    end else begin
      dv[0].valid <= v6;
    end
    dv[0].ps  <= ps6;
    dv[0].neg <= neg6;
    dv[0].uh  <= uh;
    dv[0].r   <= dd_hi[RW-1:0];
    dv[0].q   <= '0;
    dv[0].dlo <= dd[NQ-1:0];
    priority if (on_pl) begin
      dv[0].early <= 1'b1;
      dv[0].est   <= ST_ON_PLANE;
    end else if (one_sd) begin
      dv[0].early <= 1'b1;
      dv[0].est   <= ST_ONE_SIDE;
    end else if (hz6 || ovf) begin
      dv[0].early <= 1'b1;
      dv[0].est   <= ST_OUT_SPAN;
    end else begin
      dv[0].early <= 1'b0;
      dv[0].est   <= ST_HIT;
    end
  end

  // ---------------------------------------------------------------- restoring divide, a bit a stage
  for (genvar k = 0; k < NQ; k++) begin : g_div
    logic [RW:0] rs;
    logic        ge;

    always_comb begin
      rs = {dv[k].r, dv[k].dlo[NQ-1-k]};
      ge = rs >= {1'b0, dv[k].uh};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1].valid <= 1'b0;
      end else begin
        dv[k+1].valid <= dv[k].valid;
      end
      dv[k+1].ps    <= dv[k].ps;
      dv[k+1].early <= dv[k].early;
      dv[k+1].est   <= dv[k].est;
      dv[k+1].neg   <= dv[k].neg;
      dv[k+1].uh    <= dv[k].uh;
      dv[k+1].dlo   <= dv[k].dlo;
      dv[k+1].r     <= ge ? RW'(rs - {1'b0, dv[k].uh}) : rs[RW-1:0];
      dv[k+1].q     <= {dv[k].q[NQ-2:0], ge};
    end
  end

  // ---------------------------------------------------------------- R1: round quotient, sign
  logic                 v8;
  pass_t                ps8;
  logic                 early8;
  logic [1:0]           est8;
  logic signed [TW-1:0] t8;
  logic                 rb;
  logic [NQ:0]          qr;
  logic [TW-1:0]        tq;

  always_comb begin
    rb = {dv[NQ].r, 1'b0} >= {1'b0, dv[NQ].uh};
    qr = {1'b0, dv[NQ].q} + (NQ+1)'(rb);
    tq = TW'(qr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else begin
      v8 <= dv[NQ].valid;
    end
    ps8    <= dv[NQ].ps;
    early8 <= dv[NQ].early;
    est8   <= dv[NQ].est;
    t8     <= dv[NQ].neg ? -$signed(tq) : $signed(tq);
  end

  // ---------------------------------------------------------------- R2: span test, t*u, window
  logic                         v9;
  pass_t                        ps9;
  logic [1:0]                   st9;
  logic signed [TW-1:0]         t9;
  logic signed [TW-1:0]         tlo9;
  logic signed [TW-1:0]         thi9;
  logic signed [TW+UNIT_W-1:0]  m_tu [3];
  logic signed [TW-1:0]         tolx;
  logic signed [TW-1:0]         tpx;
  logic signed [TW-1:0]         lo_b;
  logic signed [TW-1:0]         hi_b;
  logic                         outs;

  always_comb begin
    tolx = $signed({{(TW-CW+1){1'b0}}, tol});
    tpx  = $signed({{(TW-CW+2){1'b0}}, tp});
    lo_b = TW'($signed(ps8.ts)) - tolx;
    hi_b = TW'($signed(ps8.te)) + tolx;
    outs = (t8 < lo_b) || (t8 > hi_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else begin
      v9 <= v8;
    end
    ps9  <= ps8;
    t9   <= t8;
    tlo9 <= t8 - tpx;
    thi9 <= t8 + tpx;
    priority if (early8) begin
      st9 <= est8;
    end else if (outs) begin
      st9 <= ST_OUT_SPAN;
    end else begin
      st9 <= ST_HIT;
    end
    for (int i = 0; i < 3; i++) begin
      m_tu[i] <= t8 * $signed(ps8.u[i]);
    end
  end

  // ---------------------------------------------------------------- R3: rescale
  logic                 v10;
  pass_t                ps10;
  logic [1:0]           st10;
  logic signed [TW-1:0] t10;
  logic signed [TW-1:0] tlo10;
  logic signed [TW-1:0] thi10;
  logic signed [RW-1:0] r_tu [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v10 <= 1'b0;
    end else begin
      v10 <= v9;
    end
    ps10  <= ps9;
    st10  <= st9;
    t10   <= t9;
    tlo10 <= tlo9;
    thi10 <= thi9;
    for (int i = 0; i < 3; i++) begin
      r_tu[i] <= rnd(MW'(m_tu[i]));
    end
  end

  // ---------------------------------------------------------------- R4: hit point, clamp, output
  logic                 hit;
  logic signed [CW-1:0] hs [3];

  always_comb begin
    hit = (st10 == ST_HIT);
    for (int i = 0; i < 3; i++) begin
      hs[i] = sat_c(RW'($signed(ps10.o[i])) + r_tu[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v10;
    end
    status  <= st10;
    tol_sum <= tol;
    t_hit   <= hit ? sat_c(RW'(t10)) : '0;
    hit_x   <= hit ? hs[0] : '0;
    hit_y   <= hit ? hs[1] : '0;
    hit_z   <= hit ? hs[2] : '0;
    t_low   <= hit ? sat_c(RW'(tlo10)) : '0;
    t_high  <= hit ? sat_c(RW'(thi10)) : '0;
  end

endmodule
